>>> sv/cxfd_pkg.sv
// ----------------------------------------------------------------------------
// cxfd_pkg: shared types and constants of the chained xor frame decryptor
// Word layouts of both channels, status codes, frame geometry and the
// length check used by the decrypt datapath.
// ----------------------------------------------------------------------------
package cxfd_pkg;

    // key and chain geometry
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int LANE_W     = $clog2(KEY_BYTES);

    // frame geometry
    localparam logic [31:0] HEAD_BYTES = 32'd4;
    localparam logic [31:0] LEN_BYTES  = 32'd4;
    localparam logic [31:0] TERM_BYTES = 32'd4;
    localparam logic [31:0] HDR_BYTES  = HEAD_BYTES + LEN_BYTES;
    localparam logic [31:0] OVERHEAD   = HEAD_BYTES + LEN_BYTES + TERM_BYTES;
    localparam logic [31:0] MIN_MSG    = 32'(2 * KEY_BYTES);
    localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_SHARED_KEY = 1'b0;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_NOT_MULT   = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_TERM   = 3'd4;
    localparam logic [2:0] ST_NO_ROOM    = 3'd5;

    typedef struct packed {
        logic [7:0]  cipher_byte;
        logic [31:0] message_length;
        logic [31:0] output_room;
        logic        end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       kind;
        logic [2:0] status;
        logic       last;
    } out_word_t;

    // decrypt step outcome handed to the output stage
    typedef struct packed {
        logic      produce;
        out_word_t word;
    } dec_result_t;

    // terminator "TrEp"
    function automatic logic [7:0] term_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = 8'h54;
            2'd1:    b = 8'h72;
            2'd2:    b = 8'h45;
            default: b = 8'h70;
        endcase
        return b;
    endfunction

    // message length sane and payload length fits inside it
    function automatic logic length_ok(input logic [31:0] m, input logic [31:0] len);
        logic [31:0] lim;
        lim = m - OVERHEAD;
        return (m >= MIN_MSG) && (m[LANE_W-1:0] == '0) && !len[31] && (len <= lim);
    endfunction

endpackage

>>> sv/chained_xor_frame_decrypt_core.sv
// ----------------------------------------------------------------------------
// chained_xor_frame_decrypt_core: streaming chained-xor frame decryptor
//
// Ciphertext words (one byte plus message length, output room and an
// end-of-message flag) enter on the s_ valid/ready channel. Each byte is
// xored with its chain lane; decrypted payload bytes leave on the m_
// channel with kind 0, and the final byte of a message yields one status
// word (kind 1, last 1). Header, length and terminator bytes give no word.
// The shared key is written over the APB-style port at byte address 0
// and is picked up at the start of the next message.
//
// Throughput: one byte per cycle while the result register can take each
// result. The input register and the result register lie between the
// edge that accepts a word and m_valid, with the whole decrypt step in
// the single logic level between them.
// A stalled receiver holds the result register; the input register still
// takes the next byte, and bytes that make no result keep flowing until a
// result needs the occupied output register.
// Reset (aresetn low, synchronous) empties both stages, clears the key,
// the chain and the frame parser.
// ----------------------------------------------------------------------------
module chained_xor_frame_decrypt_core import cxfd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // ciphertext in
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    // plaintext / status out
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    logic [KEY_W-1:0] shared_key;
    logic             in_valid_reg, in_valid_next;
    in_word_t         in_word_reg;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg;
    dec_result_t      dec_res;
    logic             out_free, advance, load_out;

    cxfd_apb u_apb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .shared_key (shared_key)
    );

    cxfd_dec u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shared_key (shared_key),
        .in_word    (in_word_reg),
        .fire       (advance),
        .result     (dec_res)
    );

    // stage handshake
    always_comb begin
        out_free       = !out_valid_reg || m_ready;
        advance        = in_valid_reg && (!dec_res.produce || out_free);
        load_out       = advance && dec_res.produce;
        s_ready        = !in_valid_reg || advance;
        in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
        out_valid_next = load_out || (out_valid_reg && !m_ready);
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_word_reg <= dec_res.word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // checks
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("pending input word lost or changed");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result register overwritten while occupied");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_PAYLOAD) |-> !m_data.last && (m_data.status == ST_OK))
        else $error("payload word carries status fields");

endmodule

>>> sv/cxfd_apb.sv
// ----------------------------------------------------------------------------
// cxfd_apb: configuration register file
// Holds the 64-bit shared key behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module cxfd_apb import cxfd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [KEY_W-1:0]   shared_key
);

    logic [KEY_W-1:0] key_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SHARED_KEY);

    // key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (wr_en) begin
            key_reg <= pwdata;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_SHARED_KEY) begin
            prdata = key_reg;
        end
    end

    assign shared_key = key_reg;

endmodule

>>> sv/cxfd_dec.sv
// ----------------------------------------------------------------------------
// cxfd_dec: per-byte decrypt and frame parser
// Chain xor, lane update, head/length capture, terminator match and the
// final status, all evaluated in one pass on the registered input word.
// ----------------------------------------------------------------------------
module cxfd_dec import cxfd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [KEY_W-1:0] shared_key,
    input  in_word_t         in_word,
    input  logic             fire,
    output dec_result_t      result
);

    logic [KEY_W-1:0]  chain_reg, chain_next, chain_cur;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       head_reg, head_next;
    logic [31:0]       len_reg, len_next;
    logic [2:0]        term_reg, term_next, term_cur;

    logic              first;
    logic [LANE_W-1:0] lane;
    logic [7:0]        key_byte, plain, neg_byte, head_byte;
    logic [31:0]       off, dt;
    logic              in_payload, emit;
    logic [2:0]        st;

    // chain lane select and decrypt
    always_comb begin
        first     = (pos_reg == '0);
        chain_cur = first ? shared_key : chain_reg;
        lane      = pos_reg[LANE_W-1:0];
        key_byte  = chain_cur[{lane, 3'b000} +: 8];
        plain     = in_word.cipher_byte ^ key_byte;
        neg_byte  = 8'h00 - in_word.cipher_byte;
        for (int i = 0; i < KEY_BYTES; i++) begin
            chain_next[8*i +: 8] = (lane == LANE_W'(i)) ? neg_byte : chain_cur[8*i +: 8];
        end
    end

    // frame parsing
    always_comb begin
        head_next  = head_reg;
        len_next   = len_reg;
        term_cur   = first ? 3'd0 : term_reg;
        term_next  = term_cur;
        head_byte  = head_reg[{~pos_reg[1:0], 3'b000} +: 8];
        off        = pos_reg - HDR_BYTES;
        dt         = off - len_reg;
        in_payload = 1'b0;
        if (pos_reg < HEAD_BYTES) begin
            head_next = {head_reg[23:0], plain};
        end else if (pos_reg < HDR_BYTES) begin
            len_next = {len_reg[23:0], plain ^ head_byte};
        end else if (off < len_reg) begin
            in_payload = 1'b1;
        end else if (dt < TERM_BYTES) begin
            if ((term_cur == {1'b0, dt[1:0]}) && (plain == term_byte(dt[1:0]))) begin
                term_next = {1'b0, dt[1:0]} + 3'd1;
            end
        end
    end

    // status of the final byte
    always_comb begin
        if (in_word.message_length < MIN_MSG) begin
            st = ST_TOO_SHORT;
        end else if (in_word.message_length[LANE_W-1:0] != '0) begin
            st = ST_NOT_MULT;
        end else if (!length_ok(in_word.message_length, len_next)) begin
            st = ST_BAD_LENGTH;
        end else if (term_next < TERM_BYTES[2:0]) begin
            st = ST_BAD_TERM;
        end else if (in_word.output_room < len_next) begin
            st = ST_NO_ROOM;
        end else begin
            st = ST_OK;
        end
    end

    // result and position
    always_comb begin
        emit = !in_word.end_of_message && in_payload
             && length_ok(in_word.message_length, len_reg);
        result.produce = in_word.end_of_message || emit;
        if (in_word.end_of_message) begin
            result.word = '{plain_byte: 8'h00, kind: KIND_STATUS, status: st, last: 1'b1};
            pos_next    = '0;
        end else begin
            result.word = '{plain_byte: plain, kind: KIND_PAYLOAD, status: ST_OK, last: 1'b0};
            pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 32'd1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
            pos_reg   <= '0;
            head_reg  <= '0;
            len_reg   <= '0;
            term_reg  <= '0;
        end else if (fire) begin
            chain_reg <= chain_next;
            pos_reg   <= pos_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
            term_reg  <= term_next;
        end
    end

    // checks
    a_eom_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_word.end_of_message |=> pos_reg == '0)
        else $error("position not cleared after final byte");

    a_pos_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_word.end_of_message && (pos_reg != POS_MAX)
        |=> pos_reg == $past(pos_reg) + 32'd1)
        else $error("position did not advance by one");

    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        term_reg <= TERM_BYTES[2:0])
        else $error("terminator match count out of range");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the chained xor frame decryptor
// Streams framed ciphertext into the core through bursty valid/ready traffic
// against a receiver with its own stall pattern, predicts every payload
// and status word in the bench, and compares each one field by field. A
// short table of hand-checked frames runs first. Random frames follow,
// under several shared keys, most of them well formed and the rest broken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cxfd_pkg::*;

    localparam int          LIMIT       = 300000;
    localparam int          N_PHASES    = 6;
    localparam int          PHASE_WORDS = 254;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [31:0] TERM_WORD   = 32'h5472_4570; // "TrEp"
    localparam logic [PADDR_W-1:0] KEY_ADDR = PADDR_W'(8 * int'(REG_SHARED_KEY));

    typedef enum int {
        FR_GOOD, FR_BAD_TERM, FR_TRUNC, FR_BAD_MLEN, FR_HUGE_LEN, FR_NO_ROOM, FR_NOISE
    } frame_kind_e;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } vec_row_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;

    chained_xor_frame_decrypt_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predictor state, mirrors the core after reset
    logic [63:0] key_reg  = '0;
    logic [63:0] chain    = '0;
    logic [31:0] pos_q    = '0;
    logic [31:0] head     = '0;
    logic [31:0] plen     = '0;
    logic [2:0]  term_cnt = '0;

    out_word_t out_due_q [$];
    in_word_t  cipher_q  [$];
    vec_row_t  dir_rows  [$];

    int cycle_cnt   = 0;
    int err_cnt     = 0;
    int sent_cnt    = 0;
    int msg_cnt     = 0;
    int payload_cnt = 0;
    int st_seen [6] = '{default: 0};
    int burst_left  = 0;
    int gap_left    = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("timeout after %0d cycles, %0d words still due", cycle_cnt, out_due_q.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    // payload length fits a sane message length
    function automatic bit frame_fits(input logic [31:0] m, input logic [31:0] len);
        return (m >= MIN_MSG) && (m[2:0] == 3'd0) && !len[31] && (len <= m - OVERHEAD);
    endfunction

    // one decrypt step: returns 1 when the byte yields a word
    function automatic bit decrypt_step(input in_word_t w, output out_word_t r);
        logic [7:0]  p;
        logic [31:0] off;
        logic [31:0] k;
        logic [2:0]  st;
        int          ln;
        bit          emit;
        emit = 1'b0;
        r    = '0;
        if (pos_q == 32'd0) begin
            chain    = key_reg;
            term_cnt = '0;
        end
        ln = int'(pos_q % 32'd8);
        p  = w.cipher_byte ^ chain[ln*8 +: 8];
        chain[ln*8 +: 8] = 8'd0 - w.cipher_byte;

        // head, twisted length, then payload and terminator
        if (pos_q < HEAD_BYTES) begin
            head = {head[23:0], p};
        end else if (pos_q < HDR_BYTES) begin
            plen = {plen[23:0], p ^ head[(32'd7 - pos_q) * 8 +: 8]};
        end else begin
            off = pos_q - HDR_BYTES;
            if (off < plen) begin
                emit = frame_fits(w.message_length, plen);
            end else if (off - plen < TERM_BYTES) begin
                k = off - plen;
                if (32'(term_cnt) == k && p == TERM_WORD[31 - 8*k -: 8])
                    term_cnt = 3'(k + 1);
            end
        end

        // final byte gives only the status word
        if (w.end_of_message) begin
            if (w.message_length < MIN_MSG)
                st = ST_TOO_SHORT;
            else if (w.message_length[2:0] != 3'd0)
                st = ST_NOT_MULT;
            else if (!frame_fits(w.message_length, plen))
                st = ST_BAD_LENGTH;
            else if (term_cnt < 3'(TERM_BYTES))
                st = ST_BAD_TERM;
            else if (w.output_room < plen)
                st = ST_NO_ROOM;
            else
                st = ST_OK;
            r.kind   = KIND_STATUS;
            r.status = st;
            r.last   = 1'b1;
            pos_q    = '0;
            msg_cnt++;
            st_seen[st]++;
            return 1'b1;
        end

        if (pos_q != POS_MAX) pos_q = pos_q + 32'd1;
        if (emit) begin
            r.plain_byte = p;
            r.kind       = KIND_PAYLOAD;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one word in bursts with random gaps, predict on acceptance
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t r;
        bit        has;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
            s_valid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent_cnt++;
        has = decrypt_step(w, r);
        if (typed)
            out_due_q.push_back(want);
        else if (has)
            out_due_q.push_back(r);
    endtask

    // wait until every due word is out and the pipe has emptied
    task automatic settle();
        s_valid <= 1'b0;
        while (out_due_q.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // key write then read back over the config port
    task automatic load_key(input logic [63:0] k);
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= PDATA_W'(k);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        key_reg = k;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (rd !== PDATA_W'(k))
            flag_error($sformatf("key readback: expected %h actual %h", k, rd));
    endtask

    function automatic void add_row(input logic [7:0] c, input logic [31:0] m,
                                    input logic [31:0] room, input logic eom,
                                    input bit typed, input logic [2:0] st);
        vec_row_t row;
        row.w     = '{c, m, room, eom};
        row.typed = typed;
        row.want  = '{8'h00, KIND_STATUS, st, 1'b1};
        dir_rows.push_back(row);
    endfunction

    // encrypt one frame of the given flavor into cipher_q
    function automatic void build_frame(input frame_kind_e fk);
        logic [7:0]  plain [$];
        logic [7:0]  lane_key [KEY_BYTES];
        logic [31:0] len, lfield, m_frame, m_field, room, hd;
        logic [7:0]  c;
        int          n_send, pick;
        in_word_t    w;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
        if (fk == FR_NO_ROOM && len == 0) len = $urandom_range(1, 40);
        m_frame = ((len + OVERHEAD + 32'd7) / 32'd8) * 32'd8 + 32'd8 * $urandom_range(0, 2);
        m_field = m_frame;
        lfield  = len;
        n_send  = int'(m_frame);
        hd      = $urandom;
        room    = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : len + $urandom_range(0, 20);

        // raw noise, message length may even wander mid-message
        if (fk == FR_NOISE) begin
            n_send  = $urandom_range(1, 40);
            m_field = $urandom_range(0, 1) ? $urandom : 32'd8 * $urandom_range(0, 8);
            room    = $urandom;
            for (int i = 0; i < n_send; i++) begin
                if ($urandom_range(0, 7) == 0) m_field = $urandom;
                w = '{8'($urandom), m_field, room, (i == n_send - 1)};
                cipher_q.push_back(w);
            end
            return;
        end

        case (fk)
            FR_TRUNC:   n_send = $urandom_range(1, m_frame - 1);
            FR_NO_ROOM: room = $urandom_range(0, len - 1);
            FR_HUGE_LEN: begin
                m_field = $urandom_range(0, 1) ? 32'hFFFF_FFF8 : {1'b1, 28'($urandom), 3'b000};
                lfield  = $urandom_range(128, 32'h7FFF_FFF0);
                n_send  = $urandom_range(9, m_frame);
                room    = $urandom;
            end
            FR_BAD_MLEN: begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       m_field = $urandom_range(0, 15);
                    1:       m_field = m_frame + $urandom_range(1, 7);
                    2:       lfield  = m_frame - OVERHEAD + $urandom_range(1, 8);
                    default: lfield  = {1'b1, 31'($urandom)};
                endcase
            end
            default: ;
        endcase

        // plaintext: head, length xored with head, payload, terminator, padding
        for (int i = 0; i < 4; i++) plain.push_back(hd[31 - 8*i -: 8]);
        for (int i = 0; i < 4; i++) plain.push_back(lfield[31 - 8*i -: 8] ^ hd[31 - 8*i -: 8]);
        for (int i = 0; i < int'(len); i++) plain.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) plain.push_back(TERM_WORD[31 - 8*i -: 8]);
        if (fk == FR_BAD_TERM) begin
            pick = int'(HDR_BYTES + len) + $urandom_range(0, 3);
            plain[pick] = plain[pick] ^ 8'(1 << $urandom_range(0, 7));
        end
        while (plain.size() < int'(m_frame)) plain.push_back(8'($urandom));

        // chained xor with the key now loaded
        for (int i = 0; i < KEY_BYTES; i++) lane_key[i] = key_reg[8*i +: 8];
        for (int i = 0; i < n_send; i++) begin
            c = plain[i] ^ lane_key[i % KEY_BYTES];
            lane_key[i % KEY_BYTES] = 8'd0 - c;
            w = '{c, m_field, room, (i == n_send - 1)};
            cipher_q.push_back(w);
        end
    endfunction

    // receiver pacing, with long hold-offs so the core backs up
    initial begin : rx_pace
        int mode;
        int mode_left;
        int hold_left;
        int holds_done;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done < 2 && sent_cnt >= 400 + holds_done * 770) begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cycle_cnt % 3 == 0);
                endcase
            end
        end
    end

    // compare each output word with the oldest due word
    always @(posedge aclk) begin : check_out
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (out_due_q.size() == 0) begin
                flag_error($sformatf("unexpected word %h at cycle %0d", m_data, cycle_cnt));
            end else begin
                want = out_due_q.pop_front();
                if (want.kind == KIND_PAYLOAD) payload_cnt++;
                if (m_data.plain_byte !== want.plain_byte || m_data.kind !== want.kind ||
                    m_data.status !== want.status || m_data.last !== want.last)
                    flag_error($sformatf(
                        "cycle %0d exp/act: byte %h/%h kind %b/%b status %0d/%0d last %b/%b",
                        cycle_cnt, want.plain_byte, m_data.plain_byte, want.kind, m_data.kind,
                        want.status, m_data.status, want.last, m_data.last));
            end
        end
    end

    initial begin : main
        frame_kind_e fk;
        logic [63:0] k;
        int          r;
        int          cut;
        int          stop_at;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hand-checked frames, key still zero from reset
        add_row(8'h00, 32'd0, 32'd0, 1'b1, 1'b1, ST_TOO_SHORT);
        add_row(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_NOT_MULT);
        // zero head, length word with its top bit set
        for (int i = 0; i < 8; i++)
            add_row((i == 4) ? 8'h80 : 8'h00, 32'd16, 32'd0, (i == 7), (i == 7), ST_BAD_LENGTH);
        // shortest good frame: zero head, empty payload, terminator, zero padding
        for (int i = 0; i < 16; i++)
            add_row((i >= 8 && i < 12) ? TERM_WORD[31 - 8*(i-8) -: 8] : 8'h00,
                    32'd16, 32'd0, (i == 15), (i == 15), ST_OK);
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       k = '1;
                2:       k = '0;
                4:       k = 64'h8000_0000_0000_0001;
                default: k = {$urandom, $urandom};
            endcase
            load_key(k);
            // rest of a frame begun under the previous key
            while (cipher_q.size() != 0) send_word(cipher_q.pop_front(), 1'b0, '0);
            stop_at = sent_cnt + PHASE_WORDS;
            while (sent_cnt < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 60)      fk = FR_GOOD;
                else if (r < 67) fk = FR_BAD_TERM;
                else if (r < 74) fk = FR_TRUNC;
                else if (r < 81) fk = FR_BAD_MLEN;
                else if (r < 86) fk = FR_HUGE_LEN;
                else if (r < 92) fk = FR_NO_ROOM;
                else             fk = FR_NOISE;
                build_frame(fk);
                while (cipher_q.size() != 0) send_word(cipher_q.pop_front(), 1'b0, '0);
            end
            // leave a frame half sent across the next key change
            if (ph == 2) begin
                build_frame(FR_GOOD);
                cut = $urandom_range(1, cipher_q.size() - 1);
                while (cipher_q.size() > cut) send_word(cipher_q.pop_front(), 1'b0, '0);
            end
            settle();
        end

        $display("covered %0d words in %0d messages under %0d keys, %0d payload bytes checked",
                 sent_cnt, msg_cnt, N_PHASES + 1, payload_cnt);
        $display("statuses ok %0d, short %0d, not multiple %0d, bad length %0d, bad term %0d, no room %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5]);
        if (err_cnt == 0 && out_due_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d words still due", err_cnt, out_due_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
